// ===== src/sfst_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sfst_pkg;

  localparam int unsigned MAX_SOURCES = 16;
  localparam int unsigned COUNT_BITS  = 8;
  localparam int unsigned IDX_W       = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;

  // event codes
  localparam logic [2:0] KIND_REGISTER   = 3'd0;
  localparam logic [2:0] KIND_USED       = 3'd1;
  localparam logic [2:0] KIND_DONE       = 3'd2;
  localparam logic [2:0] KIND_EXT_DONE   = 3'd3;
  localparam logic [2:0] KIND_TS_TIMEOUT = 3'd4;
  localparam logic [2:0] KIND_IDLE_TIMEOUT = 3'd5;
  localparam logic [2:0] KIND_QUERY      = 3'd6;

  // fix states
  localparam logic [1:0] FIX_UNKNOWN = 2'd0;
  localparam logic [1:0] FIX_YES     = 2'd1;
  localparam logic [1:0] FIX_NO      = 2'd2;

  // request result classes
  localparam logic [1:0] CLS_SUCCESS = 2'd0;
  localparam logic [1:0] CLS_PARTIAL = 2'd1;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] source_id;
    logic [1:0]  result_class;
    logic [2:0]  device_status;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [1:0]  fix_state;
    logic        state_changed;
    logic        start_timeshift;
    logic [2:0]  timeshift_status;
    logic        cancel_timeshift;
    logic        start_idle;
    logic [31:0] idle_duration;
    logic        cancel_idle;
    logic        table_full;
  } out_item_t;

  typedef struct packed {
    logic [31:0]           source;
    logic [1:0]            fix;
    logic [COUNT_BITS-1:0] pending;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // write-back control from the update logic
  typedef struct packed {
    logic we;
    logic alloc;
  } upd_ctl_t;

endpackage

`default_nettype wire

// ===== src/sfst_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sfst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== src/sfst_upd.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sfst_upd
  import sfst_pkg::*;
(
  input  wire in_item_t    item_i,
  input  wire logic        found_i,
  input  wire logic        free_ok_i,
  input  wire entry_t      ent_i,
  input  wire logic [31:0] timeout_i,
  output entry_t           ent_o,
  output upd_ctl_t         ctl_o,
  output out_item_t        res_o
);

  logic [1:0] fix;

  always_comb begin
    res_o = '0;
    ent_o = ent_i;
    ctl_o = '0;
    fix   = ent_i.fix;
    if (!found_i) begin
      if (item_i.kind == KIND_REGISTER) begin
        if (free_ok_i) begin
          ctl_o.we      = 1'b1;
          ctl_o.alloc   = 1'b1;
          ent_o.source  = item_i.source_id;
          ent_o.fix     = FIX_UNKNOWN;
          ent_o.pending = '0;
        end else begin
          res_o.table_full = 1'b1;
        end
      end
    end else begin
      res_o.found = 1'b1;
      ctl_o.we    = 1'b1;
      case (item_i.kind)
        KIND_USED: begin
          if (ent_i.pending == '0) begin
            res_o.start_timeshift  = 1'b1;
            res_o.timeshift_status = item_i.device_status;
          end
          res_o.cancel_idle = 1'b1;
          if (ent_i.pending != {COUNT_BITS{1'b1}}) begin
            ent_o.pending = ent_i.pending + COUNT_BITS'(1);
          end
        end
        KIND_DONE: begin
          if (item_i.result_class == CLS_SUCCESS) begin
            fix                    = FIX_YES;
            res_o.cancel_timeshift = 1'b1;
          end else if (item_i.result_class != CLS_PARTIAL) begin
            fix                    = FIX_NO;
            res_o.cancel_timeshift = 1'b1;
          end
          if (ent_i.pending != '0) begin
            ent_o.pending = ent_i.pending - COUNT_BITS'(1);
            if (ent_i.pending == COUNT_BITS'(1)) begin
              res_o.start_idle    = 1'b1;
              res_o.idle_duration = timeout_i;
            end
          end
        end
        KIND_EXT_DONE: begin
          if (item_i.result_class == CLS_SUCCESS) begin
            fix = FIX_YES;
          end
        end
        KIND_TS_TIMEOUT: begin
          fix = FIX_NO;
        end
        KIND_IDLE_TIMEOUT: begin
          res_o.cancel_timeshift = 1'b1;
          fix                    = FIX_UNKNOWN;
        end
        default: begin
        end
      endcase
      ent_o.fix           = fix;
      res_o.fix_state     = fix;
      res_o.state_changed = (fix != ent_i.fix);
    end
  end

endmodule

`default_nettype wire

// ===== src/source_fix_state_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Fix-state table for position sources. Pulse start with an event on item_i
// while busy is low; the block then scans its entry RAM one entry per cycle
// (one read port, registered read data), matching source_id against each
// valid entry and noting the lowest free entry on the way. The scan stops at
// the first match or after the last entry. An update state then applies the
// event and writes the entry back; busy drops when the write-back is done.
// Every event yields exactly one result: result_o is valid for a single cycle
// while done_o is high. There is no backpressure on the result side, so the
// receiver must take the result in that cycle. A new start may be given in
// the same cycle as done_o. Valid bits sit in flip-flops and are cleared by
// reset, so no clearing pass is needed. The idle timeout register is written
// through the cfg channel, accepted only while the block is idle.
module source_fix_state_table
  import sfst_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire in_item_t    item_i,
  output logic             done_o,
  output out_item_t        result_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_data_i
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_UPD} state_e;

  state_e                 state_q, state_d;
  in_item_t               item_q, item_d;
  logic [31:0]            cfg_q, cfg_d;
  logic [MAX_SOURCES-1:0] valid_q, valid_d;
  logic [IDX_W-1:0]       ptr_q, ptr_d;       // next RAM read address
  logic                   issue_q, issue_d;   // reads still to be issued
  logic                   chk_q, chk_d;       // RAM data valid for chk_idx_q
  logic [IDX_W-1:0]       chk_idx_q, chk_idx_d;
  logic                   found_q, found_d;
  logic [IDX_W-1:0]       hit_idx_q, hit_idx_d;
  entry_t                 ent_q, ent_d;
  logic                   free_ok_q, free_ok_d;
  logic [IDX_W-1:0]       free_idx_q, free_idx_d;
  out_item_t              res_q, res_d;
  logic                   done_q, done_d;

  entry_t                 rdata;
  entry_t                 wdata;
  upd_ctl_t               upd_ctl;
  out_item_t              upd_res;
  logic                   hit;
  logic                   ram_we;
  logic [IDX_W-1:0]       waddr;

  // entry store: source id, fix state and pending count per entry
  sfst_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_SOURCES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(ptr_q),
    .rdata_o(rdata)
  );

  // event semantics on the entry found by the scan
  sfst_upd u_upd (
    .item_i   (item_q),
    .found_i  (found_q),
    .free_ok_i(free_ok_q),
    .ent_i    (ent_q),
    .timeout_i(cfg_q),
    .ent_o    (wdata),
    .ctl_o    (upd_ctl),
    .res_o    (upd_res)
  );

  // a stale RAM word of a never-used entry is masked by its valid bit
  assign hit    = chk_q && valid_q[chk_idx_q] && (rdata.source == item_q.source_id);
  assign waddr  = found_q ? hit_idx_q : free_idx_q;
  assign ram_we = (state_q == ST_UPD) && upd_ctl.we;

  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign done_o      = done_q;
  assign result_o    = res_q;

  always_comb begin
    state_d    = state_q;
    item_d     = item_q;
    cfg_d      = cfg_q;
    valid_d    = valid_q;
    ptr_d      = ptr_q;
    issue_d    = issue_q;
    chk_d      = chk_q;
    chk_idx_d  = chk_idx_q;
    found_d    = found_q;
    hit_idx_d  = hit_idx_q;
    ent_d      = ent_q;
    free_ok_d  = free_ok_q;
    free_idx_d = free_idx_q;
    res_d      = res_q;
    done_d     = 1'b0;

    if (cfg_valid_i && cfg_ready_o) begin
      cfg_d = cfg_data_i;
    end

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          item_d    = item_i;
          ptr_d     = '0;
          issue_d   = 1'b1;
          chk_d     = 1'b0;
          found_d   = 1'b0;
          free_ok_d = 1'b0;
          state_d   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // read pipeline: address out this cycle, compare next cycle
        chk_d     = issue_q;
        chk_idx_d = ptr_q;
        if (issue_q) begin
          if (ptr_q == IDX_W'(MAX_SOURCES - 1)) begin
            issue_d = 1'b0;
          end else begin
            ptr_d = ptr_q + IDX_W'(1);
          end
        end
        if (chk_q) begin
          if (hit) begin
            found_d   = 1'b1;
            hit_idx_d = chk_idx_q;
            ent_d     = rdata;
            state_d   = ST_UPD;
          end else begin
            if (!valid_q[chk_idx_q] && !free_ok_q) begin
              free_ok_d  = 1'b1;
              free_idx_d = chk_idx_q;
            end
            if (chk_idx_q == IDX_W'(MAX_SOURCES - 1)) begin
              state_d = ST_UPD;
            end
          end
        end
        if (state_d == ST_UPD) begin
          issue_d = 1'b0;
          chk_d   = 1'b0;
        end
      end
      ST_UPD: begin
        res_d   = upd_res;
        done_d  = 1'b1;
        state_d = ST_IDLE;
        if (upd_ctl.alloc) begin
          valid_d[free_idx_q] = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      item_q     <= '0;
      cfg_q      <= '0;
      valid_q    <= '0;
      ptr_q      <= '0;
      issue_q    <= 1'b0;
      chk_q      <= 1'b0;
      chk_idx_q  <= '0;
      found_q    <= 1'b0;
      hit_idx_q  <= '0;
      ent_q      <= '0;
      free_ok_q  <= 1'b0;
      free_idx_q <= '0;
      res_q      <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      item_q     <= item_d;
      cfg_q      <= cfg_d;
      valid_q    <= valid_d;
      ptr_q      <= ptr_d;
      issue_q    <= issue_d;
      chk_q      <= chk_d;
      chk_idx_q  <= chk_idx_d;
      found_q    <= found_d;
      hit_idx_q  <= hit_idx_d;
      ent_q      <= ent_d;
      free_ok_q  <= free_ok_d;
      free_idx_q <= free_idx_d;
      res_q      <= res_d;
      done_q     <= done_d;
    end
  end

  // every result comes from exactly one update cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_UPD))
    else $error("result strobe without update cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) |=> done_o)
    else $error("update cycle without result strobe");

  // a refused registration never comes with a matched entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.table_full |-> !result_o.found && !$past(free_ok_q))
    else $error("table_full while a free entry was seen");

  // a new entry is only ever taken from a slot that was free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) && upd_ctl.alloc |-> !valid_q[free_idx_q])
    else $error("allocation over a valid entry");

  // a match always lands on a valid entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) && found_q |-> valid_q[hit_idx_q])
    else $error("match on an invalid entry");

endmodule

`default_nettype wire
